### design/dead_block_reuse_cache_replacement_assert.svh
// Assertion macros used by the back end of the replacement unit.
`ifndef DEAD_BLOCK_REUSE_CACHE_REPLACEMENT_ASSERT_SVH
`define DEAD_BLOCK_REUSE_CACHE_REPLACEMENT_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define DBR_ASSERT_IMP(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define DBR_ASSERT_NXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/dbr_pkg.sv
// Shared types and constants of the dead-block replacement unit.
`default_nettype none

package dbr_pkg;

    localparam int SETS_DEF       = 2048;
    localparam int WAYS_DEF       = 16;
    localparam int DECAY_BITS_DEF = 12;
    localparam int QUEUE_DEPTH    = 2;

    localparam int SET_W     = 11;
    localparam int WAY_IDX_W = 4;
    localparam int MASK_W    = 16;
    localparam int VICTIM_W  = 4;
    localparam int S_DATA_W  = 32;
    localparam int M_DATA_W  = 8;

    localparam logic [1:0] CTR_MAX    = 2'd3;
    localparam logic [1:0] FILL_REUSE = 2'd1;
    localparam logic [1:0] FILL_LIVE  = 2'd2;

    typedef enum logic
    {
        OP_VICTIM = 1'b0,
        OP_UPDATE = 1'b1
    } op_t;

    // One classified item as it travels from the front to the back.
    typedef struct packed
    {
        op_t                  op;
        logic [SET_W-1:0]     set_index;
        logic [SET_W-1:0]     set_quot;
        logic [WAY_IDX_W-1:0] way_index;
        logic                 hit;
        logic [MASK_W-1:0]    valid_mask;
        logic                 decay;
    } item_t;

endpackage

`default_nettype wire

### design/dead_block_reuse_cache_replacement.sv
// Top level of the dead-block reuse replacement unit (front, queue, back).
// A victim query passes through the queue, the registered row read and the output register.
// The back end reads a memory row, then executes, and takes no new item until it returns to idle.
// Reset: s_tready stays low for SETS cycles while the clearing pass writes every row.
// Updates produce no output beat; a query stalled on m_tready holds the back end.
`default_nettype none

module dead_block_reuse_cache_replacement #(
    parameter int SETS              = dbr_pkg::SETS_DEF,
    parameter int WAYS              = dbr_pkg::WAYS_DEF,
    parameter int DECAY_PERIOD_BITS = dbr_pkg::DECAY_BITS_DEF
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         s_tvalid,
    output logic                              s_tready,
    // s_tdata: set_index[10:0], way_index[14:11], hit[15], valid_mask[31:16]
    input  wire logic [dbr_pkg::S_DATA_W-1:0] s_tdata,
    // s_tuser: op[0]
    input  wire logic                         s_tuser,
    output logic                              m_tvalid,
    input  wire logic                         m_tready,
    // m_tdata: victim_way[3:0], zero fill [7:4]
    output logic [dbr_pkg::M_DATA_W-1:0]      m_tdata
);

    logic           push_valid;
    logic           push_ready;
    dbr_pkg::item_t push_item;
    logic           pop_valid;
    logic           pop_ready;
    dbr_pkg::item_t pop_item;
    logic           clear_busy;

    // Front: classify each beat, reduce its set index and tag decay events.
    dbr_front #(
        .SETS              (SETS),
        .DECAY_PERIOD_BITS (DECAY_PERIOD_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .enable     (!clear_busy),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item)
    );

    // Queue: decouple acceptance from execution.
    dbr_queue #(
        .DEPTH (dbr_pkg::QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_item   (pop_item)
    );

    // Back: read the row, then search for a victim or write back the updated counters.
    dbr_back #(
        .SETS (SETS),
        .WAYS (WAYS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_item   (pop_item),
        .clear_busy (clear_busy),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );

endmodule

`default_nettype wire

### design/dbr_front.sv
// Front end: accept beats, reduce the set index, run the decay access counter.
`default_nettype none

module dbr_front #(
    parameter int SETS              = dbr_pkg::SETS_DEF,
    parameter int DECAY_PERIOD_BITS = dbr_pkg::DECAY_BITS_DEF
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         s_tvalid,
    output logic                              s_tready,
    input  wire logic [dbr_pkg::S_DATA_W-1:0] s_tdata,
    input  wire logic                         s_tuser,
    input  wire logic                         enable,
    output logic                              push_valid,
    input  wire logic                         push_ready,
    output dbr_pkg::item_t                    push_item
);

    localparam int LOG_SETS = (SETS > 1) ? $clog2(SETS) : 0;
    localparam int DIV_S    = dbr_pkg::SET_W + LOG_SETS;
    localparam int MW       = DIV_S + 1;
    localparam int PROD_W   = dbr_pkg::SET_W + MW;
    localparam logic [MW-1:0] RECIP = MW'(((2 ** DIV_S) + SETS - 1) / SETS);

    logic [DECAY_PERIOD_BITS-1:0] cnt_reg;
    logic [DECAY_PERIOD_BITS-1:0] cnt_next;
    logic [dbr_pkg::SET_W-1:0]    set_in;
    logic [PROD_W-1:0]            prod;
    dbr_pkg::op_t                 op_in;
    logic                         accept;

    assign s_tready   = enable & push_ready;
    assign push_valid = s_tvalid & enable;
    assign accept     = s_tvalid & s_tready;

    assign op_in  = dbr_pkg::op_t'(s_tuser);
    assign set_in = s_tdata[10:0];

    // Quotient by reciprocal; exact for every 11-bit index.
    assign prod = PROD_W'(set_in) * PROD_W'(RECIP);

    assign cnt_next = cnt_reg + DECAY_PERIOD_BITS'(1);

    always_comb
    begin
        push_item.op         = op_in;
        push_item.set_index  = set_in;
        push_item.set_quot   = prod[DIV_S +: dbr_pkg::SET_W];
        push_item.way_index  = s_tdata[14:11];
        push_item.hit        = s_tdata[15];
        push_item.valid_mask = s_tdata[31:16];
        push_item.decay      = (op_in == dbr_pkg::OP_UPDATE) && (cnt_next == '0);
    end

    // Advance the access counter on every accepted update.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (accept && (op_in == dbr_pkg::OP_UPDATE))
        begin
            cnt_reg <= cnt_next;
        end
    end

endmodule

`default_nettype wire

### design/dbr_queue.sv
// Short item queue between the front and the back.
`default_nettype none

module dbr_queue #(
    parameter int DEPTH = dbr_pkg::QUEUE_DEPTH
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            push_valid,
    output logic                 push_ready,
    input  wire dbr_pkg::item_t  push_item,
    output logic                 pop_valid,
    input  wire logic            pop_ready,
    output dbr_pkg::item_t       pop_item
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    dbr_pkg::item_t   entries [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic             do_push;
    logic             do_pop;

    assign push_ready = (cnt_reg != CNT_W'(DEPTH));
    assign pop_valid  = (cnt_reg != '0);
    assign pop_item   = entries[rd_ptr_reg];
    assign do_push    = push_valid & push_ready;
    assign do_pop     = pop_valid & pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entries[wr_ptr_reg] <= push_item;
        end
    end

endmodule

`default_nettype wire

### design/dbr_back.sv
// Back end: counter memory, clearing pass, victim search and counter update.
`default_nettype none

`include "dead_block_reuse_cache_replacement_assert.svh"

module dbr_back #(
    parameter int SETS = dbr_pkg::SETS_DEF,
    parameter int WAYS = dbr_pkg::WAYS_DEF
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         pop_valid,
    output logic                              pop_ready,
    input  wire dbr_pkg::item_t               pop_item,
    output logic                              clear_busy,
    output logic                              m_tvalid,
    input  wire logic                         m_tready,
    output logic [dbr_pkg::M_DATA_W-1:0]      m_tdata
);

    localparam int ROW_W     = (SETS > 1) ? $clog2(SETS) : 1;
    localparam int WAY_W     = $clog2(WAYS);
    localparam int TREE_N    = 2 ** WAY_W;
    localparam int CTR_ROW_W = 2 * WAYS;
    localparam int ROW_BITS  = 4 * WAYS;
    localparam logic [ROW_BITS-1:0] CLEAR_ROW =
        {{WAYS{dbr_pkg::FILL_LIVE}}, {WAYS{dbr_pkg::FILL_REUSE}}};

    // Search classes, lowest wins.
    localparam logic [1:0] CLS_INVALID = 2'd0;
    localparam logic [1:0] CLS_DEAD    = 2'd1;
    localparam logic [1:0] CLS_LIVE    = 2'd2;
    localparam logic [1:0] CLS_PAD     = 2'd3;

    typedef enum logic [2:0]
    {
        ST_CLEAR = 3'b001,
        ST_IDLE  = 3'b010,
        ST_EXEC  = 3'b100
    } state_t;

    logic [ROW_BITS-1:0] mem [SETS];

    state_t                      state_reg;
    state_t                      state_next;
    logic [ROW_W-1:0]            clr_cnt_reg;
    logic [ROW_W-1:0]            clr_cnt_next;
    dbr_pkg::item_t              cur_reg;
    logic [ROW_W-1:0]            row_reg;
    logic [ROW_BITS-1:0]         rd_data_reg;
    logic                        out_valid_reg;
    logic                        out_valid_next;
    logic [dbr_pkg::VICTIM_W-1:0] out_way_reg;
    logic [dbr_pkg::VICTIM_W-1:0] out_way_next;

    logic                        pop;
    logic                        clr_last;
    logic [dbr_pkg::SET_W-1:0]   set_rem;
    logic [ROW_W-1:0]            pop_row;
    logic                        wr_en;
    logic [ROW_W-1:0]            wr_addr;
    logic [ROW_BITS-1:0]         wr_data;
    logic [ROW_BITS-1:0]         new_row;
    logic                        out_load;
    logic [WAY_W-1:0]            victim;

    assign pop        = pop_valid & pop_ready;
    assign pop_ready  = (state_reg == ST_IDLE);
    assign clear_busy = (state_reg == ST_CLEAR);
    assign clr_last   = (clr_cnt_reg == ROW_W'(SETS - 1));

    // Remainder from the quotient found in the front.
    assign set_rem = pop_item.set_index - dbr_pkg::SET_W'(pop_item.set_quot * SETS);
    assign pop_row = ROW_W'(set_rem);

    assign out_load = (state_reg == ST_EXEC) && (cur_reg.op == dbr_pkg::OP_VICTIM) &&
                      (!out_valid_reg || m_tready);

    assign wr_en   = (state_reg == ST_CLEAR) ||
                     ((state_reg == ST_EXEC) && (cur_reg.op == dbr_pkg::OP_UPDATE));
    assign wr_addr = (state_reg == ST_CLEAR) ? clr_cnt_reg : row_reg;
    assign wr_data = (state_reg == ST_CLEAR) ? CLEAR_ROW : new_row;

    // Decay every way of the row, then apply the hit increment or fill to the addressed way.
    always_comb
    begin
        logic [1:0] r;
        logic [1:0] l;
        new_row = rd_data_reg;
        for (int w = 0; w < WAYS; w++)
        begin
            r = rd_data_reg[2 * w +: 2];
            l = rd_data_reg[CTR_ROW_W + 2 * w +: 2];
            if (cur_reg.decay && (l != 2'd0))
            begin
                l = l - 2'd1;
            end
            if (int'(cur_reg.way_index) == w)
            begin
                if (cur_reg.hit)
                begin
                    if (r != dbr_pkg::CTR_MAX)
                    begin
                        r = r + 2'd1;
                    end
                    if (l != dbr_pkg::CTR_MAX)
                    begin
                        l = l + 2'd1;
                    end
                end
                else
                begin
                    r = dbr_pkg::FILL_REUSE;
                    l = dbr_pkg::FILL_LIVE;
                end
            end
            new_row[2 * w +: 2]             = r;
            new_row[CTR_ROW_W + 2 * w +: 2] = l;
        end
    end

    // Victim search: one key per way, reduced by a min tree, lower index on ties.
    always_comb
    begin
        logic [5:0]       key [TREE_N];
        logic [WAY_W-1:0] idx [TREE_N];
        logic [31:0]      vm_ext;
        logic [1:0]       lv;
        vm_ext = {16'hFFFF, cur_reg.valid_mask};
        for (int i = 0; i < TREE_N; i++)
        begin
            idx[i] = WAY_W'(i);
            if (i >= WAYS)
            begin
                key[i] = {CLS_PAD, 4'b0000};
            end
            else
            begin
                lv = rd_data_reg[CTR_ROW_W + 2 * i +: 2];
                if (!vm_ext[i])
                begin
                    key[i] = {CLS_INVALID, 4'b0000};
                end
                else if (lv == 2'd0)
                begin
                    key[i] = {CLS_DEAD, 4'b0000};
                end
                else
                begin
                    key[i] = {CLS_LIVE, rd_data_reg[2 * i +: 2], lv};
                end
            end
        end
        for (int lvl = 0; lvl < WAY_W; lvl++)
        begin
            for (int i = 0; i < TREE_N; i += (2 << lvl))
            begin
                if (key[i + (1 << lvl)] < key[i])
                begin
                    key[i] = key[i + (1 << lvl)];
                    idx[i] = idx[i + (1 << lvl)];
                end
            end
        end
        victim = idx[0];
    end

    assign out_way_next = dbr_pkg::VICTIM_W'(victim);

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                clr_cnt_next = clr_cnt_reg + ROW_W'(1);
                if (clr_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (pop_valid)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if ((cur_reg.op == dbr_pkg::OP_UPDATE) || out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cur_reg <= pop_item;
            row_reg <= pop_row;
        end
        if (out_load)
        begin
            out_way_reg <= out_way_next;
        end
    end

    // Counter memory: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (pop)
        begin
            rd_data_reg <= mem[pop_row];
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(dbr_pkg::M_DATA_W - dbr_pkg::VICTIM_W){1'b0}}, out_way_reg};

    `DBR_ASSERT_NXT(a_pop_enters_exec, clk, rst_n, pop, state_reg == ST_EXEC, "pop did not start execution")
    `DBR_ASSERT_NXT(a_update_one_exec, clk, rst_n, (state_reg == ST_EXEC) && (cur_reg.op == dbr_pkg::OP_UPDATE), state_reg == ST_IDLE, "update held the back end")
    `DBR_ASSERT_NXT(a_load_shows_result, clk, rst_n, out_load, m_tvalid, "loaded result not presented")
    `DBR_ASSERT_IMP(a_victim_in_range, clk, rst_n, out_load, int'(victim) < WAYS, "victim beyond way count")

endmodule

`default_nettype wire
